[rtl/tla_pkg.sv]
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types and constants for the temperature ladder acceptance update.
// ----------------------------------------------------------------------------
package tla_pkg;

  localparam int BETA_W  = 32;   // signed q16.16 inverse temperature
  localparam int CNT_W   = 32;   // exchange counters
  localparam int ACC_W   = 17;   // acceptance ratio, unsigned q1.16
  localparam int SUM_W   = 56;   // weighted sum and prefix sums
  localparam int TERM_W  = 51;   // acceptance times beta difference
  localparam int SPAN_W  = 33;   // beta difference
  localparam int IDX_W   = 6;    // replica index port
  localparam int NUM_W   = 89;   // span magnitude times prefix magnitude
  localparam int PP_W    = 61;   // one partial product
  localparam int PP_SH   = 28;   // split point of the prefix magnitude
  localparam int QW      = 42;   // quotient bits for the ladder scaling
  localparam int LOAD_QW = 17;   // quotient bits for the acceptance ratio
  localparam int STEP_W  = 6;    // divider step counter

  // scaling quotient clamp, 2^40
  localparam logic [40:0] QBIG = 41'h100_0000_0000;

  localparam logic signed [42:0] BETA_HI = 43'sd2147483647;
  localparam logic signed [42:0] BETA_LO = -43'sd2147483648;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FEW  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_WAIT,
    S_PADD,
    S_PREP,
    S_SEL,
    S_MUL0,
    S_MUL1,
    S_ADD,
    S_CHK,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic wide;    // 1: ladder scaling quotient, 0: acceptance ratio
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/tla_store.sv]
// ----------------------------------------------------------------------------
// tla_store
// Replica store: beta and acceptance ratio per ladder rung, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module tla_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [tla_pkg::BETA_W-1:0] wbeta,
  input  logic [tla_pkg::ACC_W-1:0]  wacc,
  input  logic [AW-1:0]              raddr,
  output logic [tla_pkg::BETA_W-1:0] rbeta,
  output logic [tla_pkg::ACC_W-1:0]  racc
);
  import tla_pkg::*;

  logic [BETA_W-1:0] beta_mem [DEPTH];
  logic [ACC_W-1:0]  acc_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      beta_mem[waddr] <= wbeta;
      acc_mem[waddr]  <= wacc;
    end
  end

  always_ff @(posedge clk) begin
    rbeta <= beta_mem[raddr];
    racc  <= acc_mem[raddr];
  end

endmodule

[rtl/tla_div.sv]
// ----------------------------------------------------------------------------
// tla_div
// Shared restoring divider, one quotient bit per cycle. Narrow mode gives the
// 17-bit acceptance ratio, wide mode the 42-bit ladder scaling quotient.
// ----------------------------------------------------------------------------
module tla_div (
  input  logic                      clk,
  input  logic                      rst,
  input  tla_pkg::div_req_t         req,
  input  logic [tla_pkg::NUM_W-1:0] numer,
  input  logic [tla_pkg::SUM_W-1:0] denom,
  output tla_pkg::div_rsp_t         rsp
);
  import tla_pkg::*;

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  den;
  logic [QW-1:0]     nlow;
  logic [QW-1:0]     quot;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [SUM_W:0]    trial;
  logic              fits;

  assign trial = {rem, nlow[QW-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= req.wide ? STEP_W'(QW) : STEP_W'(LOAD_QW);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // the starting remainder is below the divisor in narrow mode, and in wide mode whenever ovf is clear
  always_ff @(posedge clk) begin
    if (req.start) begin
      den  <= denom;
      quot <= '0;
      if (req.wide) begin
        rem  <= SUM_W'(numer[NUM_W-1:QW]);
        nlow <= numer[QW-1:0];
      end else begin
        rem  <= numer[LOAD_QW+SUM_W-1:LOAD_QW];
        nlow <= {numer[LOAD_QW-1:0], {(QW-LOAD_QW){1'b0}}};
      end
    end else if (busy) begin
      rem  <= fits ? SUM_W'(trial - {1'b0, den}) : trial[SUM_W-1:0];
      nlow <= {nlow[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

[rtl/temperature_ladder_acceptance_update.sv]
// ----------------------------------------------------------------------------
// temperature_ladder_acceptance_update
// Loads a parallel tempering ladder and redistributes its inverse
// temperatures by the measured exchange acceptance.
// ----------------------------------------------------------------------------
// Each beat on the input loads one replica into the replica store, but once
// the store is full, beats without last are dropped. A replica with zero
// counts is written directly; otherwise the acceptance ratio comes from the
// shared one-bit-per-cycle divider before the write. The beat with last set
// is stored and starts the update: a pass over the store forms the weighted
// sum, then each replica is read back and its new beta emitted. The end
// replicas and the zero-sum case keep their beta; an inner replica needs two
// partial products and a division for the 42-bit ladder scaling quotient.
// New input is taken again once the final result sits in the output
// register. Store contents are only read for replicas loaded in the current
// run, so the store needs no clearing after reset.
module temperature_ladder_acceptance_update #(
  parameter int MAX_REPLICAS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tla_pkg::BETA_W-1:0] beta,
  input  logic [tla_pkg::CNT_W-1:0]         accepted_count,
  input  logic [tla_pkg::CNT_W-1:0]         rejected_count,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tla_pkg::BETA_W-1:0] new_beta,
  output logic [tla_pkg::IDX_W-1:0]         replica_index,
  output logic [1:0]                        status,
  output logic                              final_res
);
  import tla_pkg::*;

  localparam int AW = $clog2(MAX_REPLICAS);
  localparam int CW = $clog2(MAX_REPLICAS + 1);

  state_t state, state_next;

  // control from the sequencer
  logic     st_we;
  logic     load_out;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // load side
  logic [CW-1:0]     cnt;
  logic              full;
  logic [AW-1:0]     idx;
  logic [SPAN_W-1:0] tot;
  logic              accept;
  logic [BETA_W-1:0] beta_hold;

  // store ports
  logic [AW-1:0]     waddr;
  logic [BETA_W-1:0] wbeta;
  logic [ACC_W-1:0]  wacc;
  logic [BETA_W-1:0] rbeta;
  logic [ACC_W-1:0]  racc;

  // ladder walk
  logic                     pass;
  logic [AW-1:0]            i;
  logic [AW-1:0]            nl;
  logic [BETA_W-1:0]        blast;
  logic [BETA_W-1:0]        b0;
  logic [BETA_W-1:0]        cur_beta;
  logic [ACC_W-1:0]         cur_acc;
  logic signed [SPAN_W-1:0] diff;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  prefix;
  logic                     prefix_neg;
  logic [SUM_W-1:0]         prefix_mag;
  logic signed [SPAN_W-1:0] span;
  logic [SPAN_W-1:0]        span_mag;
  logic                     span_neg;
  logic [SUM_W-1:0]         sum_mag;
  logic                     sum_neg;
  status_t                  st;
  logic [PP_W-1:0]          pp_lo;
  logic [PP_W-1:0]          pp_hi;
  logic [NUM_W-1:0]         numer;
  logic                     ovf;
  logic [40:0]              qc;
  logic signed [42:0]       bext;
  logic signed [42:0]       vsum;
  logic [BETA_W-1:0]        vsat;
  logic [BETA_W-1:0]        res_beta;
  logic [NUM_W-1:0]         div_numer;
  logic [SUM_W-1:0]         div_denom;

  assign accept = in_valid && in_ready;
  assign tot    = {1'b0, accepted_count} + {1'b0, rejected_count};
  assign full   = cnt >= CW'(MAX_REPLICAS);
  assign idx    = full ? AW'(MAX_REPLICAS - 1) : cnt[AW-1:0];

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    st_we         = 1'b0;
    load_out      = 1'b0;
    div_req.start = 1'b0;
    div_req.wide  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (last) begin
            st_we      = 1'b1;
            state_next = (idx == '0) ? S_EMIT : S_FETCH;
          end else if (!full) begin
            if (tot == '0) begin
              st_we = 1'b1;
            end else begin
              div_req.start = 1'b1;
              state_next    = S_LOAD;
            end
          end
        end
      end
      S_LOAD: begin
        if (div_rsp.done) begin
          st_we      = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FETCH: state_next = S_WAIT;
      S_WAIT:  state_next = S_PADD;
      S_PADD: begin
        if (pass) begin
          state_next = S_SEL;
        end else if (i == nl) begin
          state_next = S_PREP;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_PREP: state_next = S_FETCH;
      S_SEL: begin
        if (st != ST_OK || i == '0 || i == nl) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_ADD;
      S_ADD:  state_next = S_CHK;
      S_CHK: begin
        div_req.start = 1'b1;
        div_req.wide  = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: state_next = S_EMIT;
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = (i == nl) ? S_IDLE : S_FETCH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- replica store ----------------
  always_comb begin
    if (state == S_LOAD) begin
      waddr = cnt[AW-1:0];
      wbeta = beta_hold;
      wacc  = div_rsp.quot[ACC_W-1:0];
    end else begin
      waddr = last ? idx : cnt[AW-1:0];
      wbeta = beta;
      wacc  = '0;
    end
  end

  tla_store #(
    .DEPTH (MAX_REPLICAS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (waddr),
    .wbeta (wbeta),
    .wacc  (wacc),
    .raddr (i),
    .rbeta (rbeta),
    .racc  (racc)
  );

  // ---------------- shared divider ----------------
  assign div_numer = (state == S_IDLE) ? {41'b0, accepted_count, 16'b0} : numer;
  assign div_denom = (state == S_IDLE) ? SUM_W'(tot) : sum_mag;

  tla_div u_div (
    .clk   (clk),
    .rst   (rst),
    .req   (div_req),
    .numer (div_numer),
    .denom (div_denom),
    .rsp   (div_rsp)
  );

  // ---------------- datapath ----------------
  assign diff = $signed({rbeta[BETA_W-1], rbeta}) - $signed({cur_beta[BETA_W-1], cur_beta});
  assign span = $signed({blast[BETA_W-1], blast}) - $signed({b0[BETA_W-1], b0});

  assign qc   = (ovf || div_rsp.quot > QW'(QBIG)) ? QBIG : div_rsp.quot[40:0];
  assign bext = $signed({{11{b0[BETA_W-1]}}, b0});

  always_comb begin
    if (span_neg ^ prefix_neg ^ sum_neg) begin
      vsum = bext - $signed({2'b00, qc});
    end else begin
      vsum = bext + $signed({2'b00, qc});
    end
    if (vsum > BETA_HI) begin
      vsat = 32'h7fff_ffff;
    end else if (vsum < BETA_LO) begin
      vsat = 32'h8000_0000;
    end else begin
      vsat = vsum[BETA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == S_IDLE && accept) begin
      if (last) begin
        cnt <= '0;
      end else if (st_we) begin
        cnt <= cnt + CW'(1);
      end
    end else if (state == S_LOAD && div_rsp.done) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          beta_hold <= beta;
          if (last) begin
            blast    <= beta;
            nl       <= idx;
            i        <= '0;
            pass     <= 1'b0;
            prefix   <= '0;
            res_beta <= beta;
            st       <= ST_FEW;
          end
        end
      end
      S_WAIT: begin
        cur_beta <= rbeta;
        cur_acc  <= racc;
        if (i == '0) begin
          term <= '0;
        end else begin
          term <= $signed({1'b0, cur_acc}) * diff;
        end
        if (!pass && i == '0) begin
          b0 <= rbeta;
        end
      end
      S_PADD: begin
        prefix <= prefix + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
        if (!pass && i != nl) begin
          i <= i + AW'(1);
        end
      end
      S_PREP: begin
        st       <= (prefix == '0) ? ST_ZERO : ST_OK;
        sum_neg  <= prefix[SUM_W-1];
        sum_mag  <= prefix[SUM_W-1] ? SUM_W'(-prefix) : SUM_W'(prefix);
        span_neg <= span[SPAN_W-1];
        span_mag <= span[SPAN_W-1] ? SPAN_W'(-span) : SPAN_W'(span);
        pass     <= 1'b1;
        i        <= '0;
        prefix   <= '0;
      end
      S_SEL: begin
        prefix_neg <= prefix[SUM_W-1];
        prefix_mag <= prefix[SUM_W-1] ? SUM_W'(-prefix) : SUM_W'(prefix);
        res_beta   <= cur_beta;
      end
      S_MUL0: pp_lo <= span_mag * prefix_mag[PP_SH-1:0];
      S_MUL1: pp_hi <= span_mag * prefix_mag[SUM_W-1:PP_SH];
      S_ADD:  numer <= NUM_W'(pp_lo) + (NUM_W'(pp_hi) << PP_SH);
      // quotient of 2^41 or more clamps to 2^40 anyway
      S_CHK:  ovf <= {8'b0, numer[NUM_W-1:QW-1]} >= sum_mag;
      S_FIN:  res_beta <= vsat;
      S_EMIT: begin
        if (load_out && i != nl) begin
          i <= i + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      new_beta      <= res_beta;
      replica_index <= IDX_W'(i);
      status        <= st;
      final_res     <= (i == nl);
    end
  end

endmodule

[rtl/tla_chk.sv]
// ----------------------------------------------------------------------------
// tla_chk
// Port-level checks for the temperature ladder acceptance update.
// ----------------------------------------------------------------------------
module tla_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [tla_pkg::BETA_W-1:0] new_beta,
  input logic [tla_pkg::IDX_W-1:0]         replica_index,
  input logic [1:0]                        status,
  input logic                              final_res
);
  import tla_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_beta)
      && $stable(replica_index) && $stable(status) && $stable(final_res))
    else $error("result beat changed while stalled");

  // a lone replica comes back as a single final result at index zero
  a_few: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FEW |-> final_res && replica_index == '0)
    else $error("single replica result malformed");

  // loading a replica never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last && !out_valid |=> !out_valid)
    else $error("result appeared on a load beat");

  // the input is closed right after a last beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("input open straight after last beat");

endmodule

bind temperature_ladder_acceptance_update tla_chk u_tla_chk (.*);

[verif/temperature_ladder_acceptance_update_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_ladder_acceptance_update_checker
// Watches both channels of the ladder update, keeps its own copy of the
// replica store and predicts every new beta that a last beat releases.
// Each output beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module temperature_ladder_acceptance_update_checker #(
  parameter int MAX_REPLICAS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [tla_pkg::BETA_W-1:0] beta,
  input  logic [tla_pkg::CNT_W-1:0]         accepted_count,
  input  logic [tla_pkg::CNT_W-1:0]         rejected_count,
  input  logic                              last,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [tla_pkg::BETA_W-1:0] new_beta,
  input  logic [tla_pkg::IDX_W-1:0]         replica_index,
  input  logic [1:0]                        status,
  input  logic                              final_res,
  output int                                fail_count,
  output int                                pending
);

  typedef struct {
    logic signed [tla_pkg::BETA_W-1:0] new_beta;
    logic [tla_pkg::IDX_W-1:0]         idx;
    tla_pkg::status_t                  status;
    logic                              final_res;
  } rung_t;

  rung_t ladder_q[$];

  logic signed [tla_pkg::BETA_W-1:0] rung_beta   [MAX_REPLICAS];
  logic [tla_pkg::ACC_W-1:0]         rung_accept [MAX_REPLICAS];
  int                                loaded;
  longint                            weighted_sum;

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic queue_rung(longint nb, int i, tla_pkg::status_t st, logic fin);
    rung_t r;
    r.new_beta  = nb[tla_pkg::BETA_W-1:0];
    r.idx       = i[tla_pkg::IDX_W-1:0];
    r.status    = st;
    r.final_res = fin;
    ladder_q.insert(ladder_q.size(), r);
  endtask

  task automatic take_replica(logic signed [tla_pkg::BETA_W-1:0] b,
                              logic [tla_pkg::CNT_W-1:0] acc,
                              logic [tla_pkg::CNT_W-1:0] rej,
                              logic is_last);
    longint unsigned   acc_w, total, ratio;
    int                slot, n, i;
    longint            b0, span, prefix, nb;
    logic [127:0]      product, quot;
    tla_pkg::status_t  st;
    logic              neg;
    acc_w = acc;
    if (!is_last) begin
      // a full ladder drops further non-last beats
      if (loaded < MAX_REPLICAS) begin
        total = acc_w + rej;
        ratio = (total == 0) ? 0 : (acc_w << 16) / total;
        rung_beta[loaded]   = b;
        rung_accept[loaded] = ratio[tla_pkg::ACC_W-1:0];
        loaded++;
      end
      return;
    end

    slot = (loaded < MAX_REPLICAS) ? loaded : MAX_REPLICAS - 1;
    rung_beta[slot]   = b;
    rung_accept[slot] = '0;
    n      = slot + 1;
    loaded = 0;

    if (n < 2) begin
      queue_rung(rung_beta[0], 0, tla_pkg::ST_FEW, 1'b1);
      return;
    end

    weighted_sum = 0;
    for (i = 0; i < n - 1; i++)
      weighted_sum += longint'(rung_accept[i]) *
                      (longint'(rung_beta[i+1]) - longint'(rung_beta[i]));
    st = (weighted_sum == 0) ? tla_pkg::ST_ZERO : tla_pkg::ST_OK;

    b0     = rung_beta[0];
    span   = longint'(rung_beta[n-1]) - b0;
    prefix = 0;
    for (i = 0; i < n; i++) begin
      if (st != tla_pkg::ST_OK || i == 0 || i == n - 1) begin
        nb = rung_beta[i];
      end else begin
        product = 128'(mag(span)) * 128'(mag(prefix));
        quot    = product / 128'(mag(weighted_sum));
        if (quot > 128'(tla_pkg::QBIG))
          quot = 128'(tla_pkg::QBIG);
        neg = (span < 0) ^ (prefix < 0) ^ (weighted_sum < 0);
        nb  = neg ? b0 - longint'(quot[63:0]) : b0 + longint'(quot[63:0]);
        if (nb > tla_pkg::BETA_HI)
          nb = tla_pkg::BETA_HI;
        else if (nb < tla_pkg::BETA_LO)
          nb = tla_pkg::BETA_LO;
      end
      queue_rung(nb, i, st, i == n - 1);
      if (i < n - 1)
        prefix += longint'(rung_accept[i]) *
                  (longint'(rung_beta[i+1]) - longint'(rung_beta[i]));
    end
  endtask

  task automatic report_field(string field, int rung, longint want_v, longint got_v);
    $display("%0t: replica %0d %s expected %0d, actual %0d",
             $time, rung, field, want_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rung_t want;
    if (rst) begin
      loaded       = 0;
      weighted_sum = 0;
      ladder_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (ladder_q.size() == 0) begin
          $display("%0t: unexpected beat, new_beta %0d index %0d status %0d final %0b",
                   $time, new_beta, replica_index, status, final_res);
          fail_count++;
        end else begin
          want = ladder_q.pop_front();
          if (new_beta !== want.new_beta)
            report_field("new_beta", want.idx, want.new_beta, new_beta);
          if (replica_index !== want.idx)
            report_field("replica_index", want.idx, want.idx, replica_index);
          if (status !== want.status)
            report_field("status", want.idx, want.status, status);
          if (final_res !== want.final_res)
            report_field("final_res", want.idx, want.final_res, final_res);
        end
      end
      if (in_valid && in_ready)
        take_replica(beta, accepted_count, rejected_count, last);
    end
    pending = ladder_q.size();
  end

endmodule

[verif/temperature_ladder_acceptance_update_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_ladder_acceptance_update_tb
// Feeds replica ladders into the temperature ladder update: directed ladders
// for lone replicas, zero sums, counter extremes and saturation, then random
// ladders of mixed length under changing back-pressure. The checker beside
// the block predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
module temperature_ladder_acceptance_update_tb;

  localparam int MAX_REPLICAS = 32;
  localparam int ITEM_TARGET  = 420;

  localparam logic signed [tla_pkg::BETA_W-1:0] BETA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [tla_pkg::BETA_W-1:0] BETA_MIN = 32'sh8000_0000;
  localparam logic [tla_pkg::CNT_W-1:0]         CNT_FULL = 32'hFFFF_FFFF;

  logic                              clk            = 1'b0;
  logic                              rst            = 1'b1;
  logic                              in_valid       = 1'b0;
  logic                              in_ready;
  logic signed [tla_pkg::BETA_W-1:0] beta           = '0;
  logic [tla_pkg::CNT_W-1:0]         accepted_count = '0;
  logic [tla_pkg::CNT_W-1:0]         rejected_count = '0;
  logic                              last           = 1'b0;
  logic                              out_valid;
  logic                              out_ready      = 1'b0;
  logic signed [tla_pkg::BETA_W-1:0] new_beta;
  logic [tla_pkg::IDX_W-1:0]         replica_index;
  logic [1:0]                        status;
  logic                              final_res;

  int mismatches;
  int pending_results;
  int replicas_sent = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 49;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  temperature_ladder_acceptance_update #(
    .MAX_REPLICAS(MAX_REPLICAS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .beta(beta),
    .accepted_count(accepted_count),
    .rejected_count(rejected_count),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .new_beta(new_beta),
    .replica_index(replica_index),
    .status(status),
    .final_res(final_res)
  );

  temperature_ladder_acceptance_update_checker #(
    .MAX_REPLICAS(MAX_REPLICAS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .beta(beta),
    .accepted_count(accepted_count),
    .rejected_count(rejected_count),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .new_beta(new_beta),
    .replica_index(replica_index),
    .status(status),
    .final_res(final_res),
    .fail_count(mismatches),
    .pending(pending_results)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_replica(logic signed [tla_pkg::BETA_W-1:0] b,
                              logic [tla_pkg::CNT_W-1:0] acc,
                              logic [tla_pkg::CNT_W-1:0] rej,
                              logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    beta           <= b;
    accepted_count <= acc;
    rejected_count <= rej;
    last           <= is_last;
    do @(posedge clk); while (!in_ready);
    replicas_sent++;
    // swap the idling sides after a third, then run flat out
    if (replicas_sent == ITEM_TARGET / 3) begin
      send_idle_pct = 49;
      recv_idle_pct = 38;
    end else if (replicas_sent == 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic random_ladder(int len);
    int                                k, shape;
    logic signed [tla_pkg::BETA_W-1:0] b;
    logic [tla_pkg::CNT_W-1:0]         acc, rej;
    shape = $urandom_range(3);
    b = (shape == 0) ? $urandom() : $urandom_range(32'h0004_0000);
    for (k = 0; k < len - 1; k++) begin
      case ($urandom_range(5))
        0: begin acc = $urandom();              rej = $urandom();              end
        1: begin acc = $urandom_range(1000);    rej = $urandom_range(1000);    end
        2: begin acc = '0;                      rej = '0;                      end
        3: begin acc = '0;                      rej = $urandom();              end
        4: begin acc = $urandom();              rej = '0;                      end
        default: begin acc = $urandom_range(20); rej = $urandom_range(20);     end
      endcase
      push_replica(b, acc, rej, 1'b0);
      // flat ladders keep every beta equal, so the weighted sum is zero
      case (shape)
        0:       b = $urandom();
        3:       b = b;
        default: b = b + $urandom_range(1, 32'h0000_8000);
      endcase
    end
    push_replica(b, $urandom(), $urandom(), 1'b1);
  endtask

  initial begin
    int sel;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lone replicas at both ends of the range
    push_replica(BETA_MAX, CNT_FULL, CNT_FULL, 1'b1);
    push_replica(BETA_MIN, '0, '0, 1'b1);
    // every acceptance zero
    push_replica(32'sd100, '0, '0, 1'b0);
    push_replica(-32'sd5, '0, '0, 1'b0);
    push_replica(32'sd7, '0, '0, 1'b1);
    // counter extremes
    push_replica(32'sh0000_0000, CNT_FULL, CNT_FULL, 1'b0);
    push_replica(32'sh0001_0000, CNT_FULL, '0, 1'b0);
    push_replica(32'sh0001_8000, '0, CNT_FULL, 1'b0);
    push_replica(32'sh0002_0000, CNT_FULL, CNT_FULL, 1'b1);
    // tiny negative sum, quotient clamps and the inner beta saturates low
    push_replica(BETA_MAX, 32'd1, 32'd1, 1'b0);
    push_replica(BETA_MIN, 32'd7, '0, 1'b0);
    push_replica(-32'sd1, '0, '0, 1'b1);
    // mirror image, saturates high
    push_replica(BETA_MIN, 32'd1, 32'd1, 1'b0);
    push_replica(BETA_MAX, 32'd7, '0, 1'b0);
    push_replica(32'sd0, '0, '0, 1'b1);
    // two replicas, ends only
    push_replica(-32'sd65536, 32'd3, 32'd1, 1'b0);
    push_replica(32'sd65536, '0, '0, 1'b1);

    // overfilled ladder first, then a mix of lengths
    random_ladder(MAX_REPLICAS + 2);
    while (replicas_sent < ITEM_TARGET) begin
      sel = $urandom_range(19);
      if (sel == 0)
        random_ladder(1);
      else if (sel == 1)
        random_ladder($urandom_range(MAX_REPLICAS - 2, MAX_REPLICAS + 4));
      else if (sel < 5)
        random_ladder($urandom_range(7, 20));
      else
        random_ladder($urandom_range(2, 6));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (mismatches == 0)
      $display("temperature_ladder_acceptance_update: match");
    else
      $display("temperature_ladder_acceptance_update: mismatch");
    $finish;
  end

  initial begin
    #(64'd2_000_000);
    $display("temperature_ladder_acceptance_update: mismatch");
    $finish;
  end

endmodule
